// File: rtl/can_id_filter_uart_framer_assert.svh
// Assertion macros used by the checker file.
`ifndef CAN_ID_FILTER_UART_FRAMER_ASSERT_SVH
`define CAN_ID_FILTER_UART_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CIFU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CIFU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cifu_pkg.sv
// ----------------------------------------------------------------------------
// cifu_pkg
// Types, codes and helpers shared by the CAN ID filter / UART framer block.
// ----------------------------------------------------------------------------
package cifu_pkg;

  localparam int SLOT_W = 6;
  localparam int ID_W   = 32;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 4;

  localparam logic [LEN_W-1:0]  MAX_LEN    = 4'd8;
  localparam logic [BYTE_W-1:0] START_BYTE = 8'hAA;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FRAME = 2'd1,
    REQ_DRAIN = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   can_id;
    logic [LEN_W-1:0]  frame_len;
    logic [DATA_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              frame_end;
    logic [SLOT_W-1:0] drained_slot;
  } tx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MATCH,
    ST_SEEK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic scan_step;
    logic frame_wr;
    logic drain_load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic match_hit;
    logic pend_hit;
    logic exhausted;
    logic tx_free;
    logic last;
  } status_t;

  // Keep the first len bytes of a frame payload.
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    for (int b = 0; b < DATA_W / BYTE_W; b++) begin
      m[b*BYTE_W +: BYTE_W] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: rtl/can_id_filter_uart_framer.sv
// ----------------------------------------------------------------------------
// can_id_filter_uart_framer
// CAN-to-UART mailbox gateway with ID filter table and XOR-checked framing.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_stall is high while it is in work.
// A load captures the request, then writes its table entry. A received frame
// or a drain scans the table one entry per cycle through the table memory's
// single read port, ending early at the first match or pending entry.
// A drain that finds an entry then sends length + 7 bytes (up to 15), one per
// cycle while tx_stall is low. The last byte sits in the output register, so
// the next request is taken while it waits. No clearing pass after reset.
module can_id_filter_uart_framer #(
  parameter int ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cifu_pkg::req_t req_data,
  output logic           tx_valid,
  input  logic           tx_stall,
  output cifu_pkg::tx_t  tx_data
);

  cifu_pkg::cmd_t    cmd;
  cifu_pkg::status_t status;

  cifu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_data.req_type),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cifu_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .status   (status),
    .tx_stall (tx_stall),
    .tx_valid (tx_valid),
    .tx_data  (tx_data)
  );

endmodule

// File: rtl/cifu_ctrl.sv
// ----------------------------------------------------------------------------
// cifu_ctrl
// Request sequencer: load, table scan for match or pending, frame emission.
// ----------------------------------------------------------------------------
module cifu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_type,
  output logic              req_stall,
  input  cifu_pkg::status_t status,
  output cifu_pkg::cmd_t    cmd
);

  cifu_pkg::state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cifu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      cifu_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          unique case (req_type)
            cifu_pkg::REQ_LOAD:  state_next = cifu_pkg::ST_LOAD;
            cifu_pkg::REQ_FRAME: state_next = cifu_pkg::ST_MATCH;
            cifu_pkg::REQ_DRAIN: state_next = cifu_pkg::ST_SEEK;
            default:             state_next = cifu_pkg::ST_IDLE;
          endcase
        end
      end
      cifu_pkg::ST_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next  = cifu_pkg::ST_IDLE;
      end
      cifu_pkg::ST_MATCH: begin
        cmd.scan_step = 1'b1;
        if (status.match_hit) begin
          cmd.frame_wr = 1'b1;
          state_next   = cifu_pkg::ST_IDLE;
        end else if (status.exhausted) begin
          state_next = cifu_pkg::ST_IDLE;
        end
      end
      cifu_pkg::ST_SEEK: begin
        cmd.scan_step = 1'b1;
        if (status.pend_hit) begin
          cmd.drain_load = 1'b1;
          state_next     = cifu_pkg::ST_EMIT;
        end else if (status.exhausted) begin
          state_next = cifu_pkg::ST_IDLE;
        end
      end
      cifu_pkg::ST_EMIT: begin
        if (status.tx_free) begin
          cmd.emit = 1'b1;
          if (status.last) begin
            state_next = cifu_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = cifu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/cifu_datapath.sv
// ----------------------------------------------------------------------------
// cifu_datapath
// Filter table memories, scan pointer, emit registers and output register.
// ----------------------------------------------------------------------------
module cifu_datapath #(
  parameter int ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  cifu_pkg::req_t    req_data,
  input  cifu_pkg::cmd_t    cmd,
  output cifu_pkg::status_t status,
  input  logic              tx_stall,
  output logic              tx_valid,
  output cifu_pkg::tx_t     tx_data
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = cifu_pkg::ID_W + cifu_pkg::LEN_W;

  // Captured request
  logic [cifu_pkg::SLOT_W-1:0] slot_q;
  logic [cifu_pkg::ID_W-1:0]   can_id_q;
  logic [cifu_pkg::LEN_W-1:0]  len_q;
  logic [cifu_pkg::DATA_W-1:0] payload_q;

  // Table storage
  logic [WORD_W-1:0]           id_mem    [ENTRIES];
  logic [cifu_pkg::DATA_W-1:0] bytes_mem [ENTRIES];
  logic [ENTRIES-1:0]          valid;
  logic [ENTRIES-1:0]          pending;

  // Scan pipeline
  logic [CNT_W-1:0]            cnt;
  logic                        rd_vld;
  logic [IDX_W-1:0]            rd_idx;
  logic [WORD_W-1:0]           rd_word;
  logic [cifu_pkg::DATA_W-1:0] rd_bytes;
  logic                        rd_valid_bit;
  logic                        rd_pend;

  // Emit registers
  logic [cifu_pkg::ID_W-1:0]   e_id;
  logic [cifu_pkg::LEN_W-1:0]  e_len;
  logic [cifu_pkg::DATA_W-1:0] e_bytes;
  logic [IDX_W-1:0]            e_slot;
  logic [cifu_pkg::POS_W-1:0]  pos;
  logic [cifu_pkg::BYTE_W-1:0] sum;

  logic                        slot_ok;
  logic [IDX_W-1:0]            ld_addr;
  logic [IDX_W-1:0]            cnt_idx;
  logic                        scan_rd;
  logic [cifu_pkg::ID_W-1:0]   rd_id;
  logic [cifu_pkg::LEN_W-1:0]  rd_len;
  logic                        last;
  logic [cifu_pkg::BYTE_W-1:0] next_byte;
  logic                        shift_id;
  logic                        shift_data;

  assign slot_ok = ({1'b0, slot_q} < 7'(ENTRIES));
  assign ld_addr = slot_q[IDX_W-1:0];
  assign cnt_idx = cnt[IDX_W-1:0];
  assign scan_rd = cmd.scan_step && (cnt < CNT_W'(ENTRIES));
  assign rd_id   = rd_word[WORD_W-1:cifu_pkg::LEN_W];
  assign rd_len  = rd_word[cifu_pkg::LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_q    <= req_data.slot;
      can_id_q  <= req_data.can_id;
      len_q     <= (req_data.frame_len > cifu_pkg::MAX_LEN) ? cifu_pkg::MAX_LEN
                                                           : req_data.frame_len;
      payload_q <= req_data.payload;
    end
  end

  // Table memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) begin
      id_mem[ld_addr] <= {can_id_q, len_q};
    end
    if (cmd.load_wr && slot_ok) begin
      bytes_mem[ld_addr] <= '0;
    end else if (cmd.frame_wr) begin
      bytes_mem[rd_idx] <= payload_q & cifu_pkg::byte_mask(rd_len);
    end
    if (scan_rd) begin
      rd_word  <= id_mem[cnt_idx];
      rd_bytes <= bytes_mem[cnt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (scan_rd) begin
      rd_idx       <= cnt_idx;
      rd_valid_bit <= valid[cnt_idx];
      rd_pend      <= pending[cnt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      pending <= '0;
    end else begin
      if (cmd.load_wr && slot_ok) begin
        valid[ld_addr]   <= 1'b1;
        pending[ld_addr] <= 1'b0;
      end
      if (cmd.frame_wr) begin
        pending[rd_idx] <= 1'b1;
      end
      if (cmd.drain_load) begin
        pending[rd_idx] <= 1'b0;
      end
    end
  end

  // Scan pointer: one table entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.capture) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_vld <= scan_rd;
      if (scan_rd) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign status.match_hit = rd_vld && rd_valid_bit && (rd_id == can_id_q);
  assign status.pend_hit  = rd_vld && rd_pend;
  assign status.exhausted = !rd_vld && (cnt == CNT_W'(ENTRIES));
  assign status.tx_free   = !tx_valid || !tx_stall;
  assign status.last      = last;

  // Byte order: sync, ID low byte first, length, data, checksum
  assign last = (pos == (e_len + 4'd6));

  always_comb begin
    next_byte  = cifu_pkg::START_BYTE;
    shift_id   = 1'b0;
    shift_data = 1'b0;
    case (pos) inside
      4'd0: begin
        next_byte = cifu_pkg::START_BYTE;
      end
      [4'd1:4'd4]: begin
        next_byte = e_id[cifu_pkg::BYTE_W-1:0];
        shift_id  = 1'b1;
      end
      4'd5: begin
        next_byte = {4'd0, e_len};
      end
      default: begin
        if (last) begin
          next_byte = sum;
        end else begin
          next_byte  = e_bytes[cifu_pkg::BYTE_W-1:0];
          shift_data = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_load) begin
      e_id    <= rd_id;
      e_len   <= rd_len;
      e_bytes <= rd_bytes;
      e_slot  <= rd_idx;
      pos     <= '0;
      sum     <= {4'd0, rd_len};
    end else if (cmd.emit) begin
      pos <= pos + 1'b1;
      if (shift_id) begin
        e_id <= e_id >> cifu_pkg::BYTE_W;
      end
      if (shift_data) begin
        e_bytes <= e_bytes >> cifu_pkg::BYTE_W;
        sum     <= sum ^ e_bytes[cifu_pkg::BYTE_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (cmd.emit) begin
      tx_valid <= 1'b1;
    end else if (!tx_stall) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tx_data.tx_byte      <= next_byte;
      tx_data.frame_end    <= last;
      tx_data.drained_slot <= cifu_pkg::SLOT_W'(e_slot);
    end
  end

endmodule

// File: rtl/cifu_checker.sv
// ----------------------------------------------------------------------------
// cifu_checker
// Port-level checks on the request handshake and the serial frame stream of the gateway.
// ----------------------------------------------------------------------------
`include "can_id_filter_uart_framer_assert.svh"

module cifu_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input cifu_pkg::req_t req_data,
  input logic           tx_valid,
  input logic           tx_stall,
  input cifu_pkg::tx_t  tx_data
);

  logic                        in_frame;
  logic [3:0]                  nbytes;
  logic [cifu_pkg::SLOT_W-1:0] cur_slot;
  logic                        tx_xfer;

  assign tx_xfer = tx_valid && !tx_stall;

  // Track position within the frame being sent
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      nbytes   <= '0;
    end else if (tx_xfer) begin
      if (tx_data.frame_end) begin
        in_frame <= 1'b0;
        nbytes   <= '0;
      end else begin
        in_frame <= 1'b1;
        nbytes   <= nbytes + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tx_xfer) begin
      cur_slot <= tx_data.drained_slot;
    end
  end

  `CIFU_ASSERT_NXT(a_req_hold, clk, rst, req_valid && req_stall,
    req_valid && $stable(req_data), "stalled request changed")
  `CIFU_ASSERT_NXT(a_tx_hold, clk, rst, tx_valid && tx_stall,
    tx_valid && $stable(tx_data), "stalled transfer changed")
  `CIFU_ASSERT_IMP(a_sync_first, clk, rst, tx_valid && !in_frame,
    tx_data.tx_byte == cifu_pkg::START_BYTE && !tx_data.frame_end, "frame not opened by sync")
  `CIFU_ASSERT_IMP(a_slot_steady, clk, rst, tx_valid && in_frame,
    tx_data.drained_slot == cur_slot, "slot changed within frame")
  `CIFU_ASSERT_IMP(a_frame_bound, clk, rst, tx_valid && nbytes == 4'd14,
    tx_data.frame_end, "frame longer than fifteen bytes")

endmodule

bind can_id_filter_uart_framer cifu_checker u_cifu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_data  (req_data),
  .tx_valid  (tx_valid),
  .tx_stall  (tx_stall),
  .tx_data   (tx_data)
);

// File: test/can_id_filter_uart_framer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_id_filter_uart_framer_test
// Self-checking bench for the CAN-to-UART mailbox gateway. Requests come from
// a backlog queue through a clocked driver with random gaps. Each accepted
// request updates a local copy of the filter table, and any drained frame is
// queued as the UART bytes due. A clocked monitor compares every byte sent
// against the oldest byte due, with random output stalls.
// ----------------------------------------------------------------------------
module can_id_filter_uart_framer_test;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 480;
  localparam int IDLE_PCT = 21;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    cifu_pkg::req_t req;
    logic wait_empty;
  } backlog_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  cifu_pkg::req_t req_data = '0;
  logic tx_valid;
  logic tx_stall = 1'b0;
  cifu_pkg::tx_t tx_data;

  // Local copy of the filter table
  logic [cifu_pkg::ID_W-1:0] tbl_id [TABLE_DEPTH];
  logic [cifu_pkg::LEN_W-1:0] tbl_len [TABLE_DEPTH];
  logic [cifu_pkg::DATA_W-1:0] tbl_data [TABLE_DEPTH];
  bit tbl_valid [TABLE_DEPTH];
  bit tbl_pend [TABLE_DEPTH];

  // Shadow used while building stimulus, to tell which requests do something
  logic [cifu_pkg::ID_W-1:0] gen_id [TABLE_DEPTH];
  bit gen_valid [TABLE_DEPTH];
  bit gen_pend [TABLE_DEPTH];

  backlog_t req_backlog [$];
  cifu_pkg::tx_t uart_bytes_due [$];

  cifu_pkg::req_t cur_req;
  bit req_loaded = 0;
  bit on_wire = 0;
  bit req_fired = 0;
  bit quiet = 0;
  int cycle_count = 0;
  int idle_cycles = 0;
  int fail_count = 0;

  can_id_filter_uart_framer dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .tx_valid(tx_valid),
    .tx_stall(tx_stall),
    .tx_data(tx_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
  end

  function automatic cifu_pkg::tx_t uart_byte(input logic [cifu_pkg::BYTE_W-1:0] b,
                                              input logic last, input int s);
    cifu_pkg::tx_t t;
    t.tx_byte = b;
    t.frame_end = last;
    t.drained_slot = cifu_pkg::SLOT_W'(s);
    return t;
  endfunction

  // Apply one request to the table copy and queue any frame it drains.
  task automatic mailbox_update(input cifu_pkg::req_t r);
    int hit;
    logic [cifu_pkg::LEN_W-1:0] len;
    logic [cifu_pkg::DATA_W-1:0] keep;
    logic [cifu_pkg::BYTE_W-1:0] sum;
    logic [cifu_pkg::BYTE_W-1:0] b;
    hit = -1;
    case (r.req_type)
      cifu_pkg::REQ_LOAD: begin
        tbl_id[r.slot] = r.can_id;
        tbl_len[r.slot] = (r.frame_len > cifu_pkg::MAX_LEN) ? cifu_pkg::MAX_LEN
                                                            : r.frame_len;
        tbl_data[r.slot] = '0;
        tbl_pend[r.slot] = 0;
        tbl_valid[r.slot] = 1;
      end
      cifu_pkg::REQ_FRAME: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (hit < 0 && tbl_valid[i] && tbl_id[i] == r.can_id) hit = i;
        if (hit >= 0) begin
          len = tbl_len[hit];
          keep = (len >= cifu_pkg::MAX_LEN) ? '1 : ((64'd1 << {len, 3'b000}) - 64'd1);
          tbl_data[hit] = (tbl_data[hit] & ~keep) | (r.payload & keep);
          tbl_pend[hit] = 1;
        end
      end
      cifu_pkg::REQ_DRAIN: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (hit < 0 && tbl_pend[i]) hit = i;
        if (hit >= 0) begin
          tbl_pend[hit] = 0;
          len = tbl_len[hit];
          uart_bytes_due.push_back(uart_byte(cifu_pkg::START_BYTE, 1'b0, hit));
          for (int j = 0; j < 4; j++)
            uart_bytes_due.push_back(uart_byte(tbl_id[hit][j*8 +: 8], 1'b0, hit));
          uart_bytes_due.push_back(uart_byte({4'h0, len}, 1'b0, hit));
          sum = {4'h0, len};
          for (int j = 0; j < int'(len); j++) begin
            b = tbl_data[hit][j*8 +: 8];
            sum = sum ^ b;
            uart_bytes_due.push_back(uart_byte(b, 1'b0, hit));
          end
          uart_bytes_due.push_back(uart_byte(sum, 1'b1, hit));
        end
      end
      default: ;
    endcase
  endtask

  // Track the table roughly while building stimulus; true if r changes anything.
  function automatic bit request_has_effect(input cifu_pkg::req_t r);
    case (r.req_type)
      cifu_pkg::REQ_LOAD: begin
        gen_valid[r.slot] = 1;
        gen_id[r.slot] = r.can_id;
        gen_pend[r.slot] = 0;
        return 1;
      end
      cifu_pkg::REQ_FRAME: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (gen_valid[i] && gen_id[i] == r.can_id) begin
            gen_pend[i] = 1;
            return 1;
          end
      end
      cifu_pkg::REQ_DRAIN: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (gen_pend[i]) begin
            gen_pend[i] = 0;
            return 1;
          end
      end
      default: ;
    endcase
    return 0;
  endfunction

  function automatic cifu_pkg::req_t make_req(input logic [1:0] kind,
                                              input logic [cifu_pkg::SLOT_W-1:0] s,
                                              input logic [cifu_pkg::ID_W-1:0] id,
                                              input logic [cifu_pkg::LEN_W-1:0] len,
                                              input logic [cifu_pkg::DATA_W-1:0] data);
    cifu_pkg::req_t r;
    r.req_type = kind;
    r.slot = s;
    r.can_id = id;
    r.frame_len = len;
    r.payload = data;
    return r;
  endfunction

  function automatic logic [cifu_pkg::DATA_W-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  // Stimulus
  initial begin
    logic [cifu_pkg::ID_W-1:0] id_pool [6];
    backlog_t entry;
    cifu_pkg::req_t r;
    int pick;
    int s;
    int effective;
    int next_hold;

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 0;
      tbl_pend[i] = 0;
      tbl_id[i] = '0;
      tbl_len[i] = '0;
      tbl_data[i] = '0;
      gen_valid[i] = 0;
      gen_pend[i] = 0;
      gen_id[i] = '0;
    end

    // Directed: empty drain, unused code, length extremes and saturation,
    // duplicate IDs, unmatched frame, reload clearing a pending entry.
    req_backlog.push_back({make_req(cifu_pkg::REQ_DRAIN, 6'($urandom), $urandom,
                                    4'($urandom), rand_data()), 1'b0});
    req_backlog.push_back({make_req(REQ_UNUSED, 6'($urandom), $urandom, 4'($urandom),
                                    rand_data()), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_LOAD, 6'd0, 32'h0, 4'd0, '1), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_LOAD, 6'd63, 32'hFFFF_FFFF, 4'd8, '1),
                           1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_LOAD, 6'd5, 32'h1234_5678, 4'd15, '0),
                           1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_LOAD, 6'd9, 32'h1234_5678, 4'd3, '0),
                           1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_LOAD, 6'd12, 32'h0BAD_F00D, 4'd3, '0),
                           1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_FRAME, 6'd0, 32'h0, 4'd0, '1), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_FRAME, 6'd0, 32'hFFFF_FFFF, 4'd0,
                                    64'hFEDC_BA98_7654_3210), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_FRAME, 6'd63, 32'h1234_5678, 4'd15,
                                    rand_data()), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_FRAME, 6'd1, 32'hDEAD_BEEF, 4'd8, '1),
                           1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_FRAME, 6'd2, 32'h0BAD_F00D, 4'd2,
                                    64'h0123_4567_89AB_CDEF), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_FRAME, 6'd2, 32'h0BAD_F00D, 4'd2, '1),
                           1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_DRAIN, 6'd0, 32'h0, 4'd0, '0), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_DRAIN, 6'd63, '1, 4'd15, '1), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_DRAIN, 6'd0, 32'h0, 4'd0, '0), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_DRAIN, 6'd0, 32'h0, 4'd0, '0), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_DRAIN, 6'd0, 32'h0, 4'd0, '0), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_FRAME, 6'd0, 32'hFFFF_FFFF, 4'd0,
                                    rand_data()), 1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_LOAD, 6'd63, 32'hFFFF_FFFF, 4'd2, '0),
                           1'b0});
    req_backlog.push_back({make_req(cifu_pkg::REQ_DRAIN, 6'd0, 32'h0, 4'd0, '0), 1'b0});
    foreach (req_backlog[i]) pick = request_has_effect(req_backlog[i].req);

    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 6; i++) id_pool[i] = $urandom;

    // Random: mostly loads into a few slots and frames that hit them, so that
    // duplicates, partial overwrites and back-to-back drains are common.
    effective = 0;
    next_hold = 0;
    while (req_backlog.size() < RANDOM_ITEMS) begin
      r = make_req(REQ_UNUSED, 6'($urandom), $urandom, 4'($urandom), rand_data());
      pick = $urandom_range(0, 99);
      s = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 63);
      if (pick < 18) begin
        r.req_type = cifu_pkg::REQ_LOAD;
        r.slot = cifu_pkg::SLOT_W'(s);
        if ($urandom_range(0, 9) < 7) r.can_id = id_pool[$urandom_range(0, 5)];
      end else if (pick < 55) begin
        r.req_type = cifu_pkg::REQ_FRAME;
        if (gen_valid[s] && $urandom_range(0, 99) < 85) r.can_id = gen_id[s];
      end else if (pick < 93) begin
        r.req_type = cifu_pkg::REQ_DRAIN;
      end
      entry.req = r;
      // Hold the sender until the output has run dry, now and then
      entry.wait_empty = (effective >= next_hold);
      if (entry.wait_empty) next_hold = effective + 120;
      req_backlog.push_back(entry);
      if (request_has_effect(r)) effective++;
    end

    while (req_backlog.size() != 0 || req_loaded || uart_bytes_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (uart_bytes_due.size() != 0) begin
      $error("%0d tx bytes never sent", uart_bytes_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver: change inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      tx_stall <= 1'b0;
    end else begin
      quiet = (cycle_count >= 2000 && cycle_count < 5000);
      tx_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      if (req_fired) begin
        req_fired = 0;
        req_loaded = 0;
        on_wire = 0;
      end
      if (!req_loaded && req_backlog.size() != 0) begin
        if (!(req_backlog[0].wait_empty && uart_bytes_due.size() != 0)) begin
          cur_req = req_backlog.pop_front().req;
          req_loaded = 1;
        end
      end
      if (req_loaded && !on_wire) begin
        if (quiet || $urandom_range(0, 99) >= IDLE_PCT) begin
          on_wire = 1;
          req_data <= cur_req;
        end
      end
      req_valid <= on_wire;
    end
  end

  // Monitor: sample on the rising edge
  always @(posedge clk) begin
    cifu_pkg::tx_t want;
    bit moved;
    if (!rst) begin
      moved = 0;
      cycle_count++;
      if (req_valid && !req_stall) begin
        mailbox_update(req_data);
        req_fired = 1;
        moved = 1;
      end
      if (tx_valid && !tx_stall) begin
        moved = 1;
        if (uart_bytes_due.size() == 0) begin
          $error("unexpected tx byte %h from slot %0d", tx_data.tx_byte,
                 tx_data.drained_slot);
          fail_count++;
        end else begin
          want = uart_bytes_due.pop_front();
          if (tx_data.tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %h, got %h", want.tx_byte, tx_data.tx_byte);
            fail_count++;
          end
          if (tx_data.frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, tx_data.frame_end);
            fail_count++;
          end
          if (tx_data.drained_slot !== want.drained_slot) begin
            $error("drained_slot: expected %0d, got %0d", want.drained_slot,
                   tx_data.drained_slot);
            fail_count++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
